>>> rtl/core/page_framebuffer_area_fill_macros.svh
// Assertion macros shared by the framebuffer fill RTL.
`ifndef PAGE_FRAMEBUFFER_AREA_FILL_MACROS_SVH
`define PAGE_FRAMEBUFFER_AREA_FILL_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define PFAF_ASSERT_IMPLIES(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("pfaf assertion failed");
// next-cycle implication
`define PFAF_ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("pfaf assertion failed");
`else
`define PFAF_ASSERT_IMPLIES(label, clk, rst_n, a, b)
`define PFAF_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif

`endif

>>> rtl/core/pfaf_pkg.sv
`default_nettype none
package pfaf_pkg;

	localparam int DISPLAY_COLUMNS_DEF = 128;
	localparam int DISPLAY_PAGES_DEF   = 8;
	localparam int PAGE_ROWS           = 8;
	localparam logic [7:0] MASK_ALL    = 8'hff;

	typedef enum logic [1:0] {
		REQ_FILL       = 2'd0,
		REQ_READ       = 2'd1,
		REQ_TAKE_DIRTY = 2'd2,
		REQ_CLEAR      = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		OP_OR     = 2'd0,
		OP_ANDNOT = 2'd1,
		OP_XOR    = 2'd2,
		OP_SET    = 2'd3
	} op_t;

	// raster op on one column byte
	function automatic logic [7:0] apply_op(input logic [7:0] old, input logic [7:0] mask,
			input op_t op);
		logic [7:0] res;
		unique case (op) inside
			OP_ANDNOT:     res = old & ~mask;
			OP_XOR:        res = old ^ mask;
			OP_OR, OP_SET: res = old | mask;
			default:       res = old | mask;
		endcase
		return res;
	endfunction

endpackage
`default_nettype wire

>>> rtl/core/page_framebuffer_area_fill.sv
`default_nettype none
// Monochrome page framebuffer with rectangle fill, byte read-back and dirty-page mask.
// Requests: drive the fields and raise start; a request is taken at an edge where
// start is high and busy is low. Every request gives exactly one result, shown on
// read_data, dirty_pages and start_error for the single cycle in which done is high.
// The receiver cannot stall; results must be taken when done is high.
// States between the accepting edge and done:
//   take dirty mask, rejected fill, zero-width fill : none, done is set from ST_IDLE
//   read byte                                       : ST_READ
//   fill                                            : ST_FILL per column byte, then ST_FLUSH
//   clear display                                   : ST_CLR over every address
// A fill does one read-modify-write per column byte; the RAM read port issues one
// address a cycle and the write lands the cycle after.
// Requests are handled one at a time (busy high while at work).
// After reset the block sweeps the whole store to zero, one entry a cycle, with busy
// high; the dirty mask resets to all ones.
module page_framebuffer_area_fill #(
	parameter int DISPLAY_COLUMNS = pfaf_pkg::DISPLAY_COLUMNS_DEF,
	parameter int DISPLAY_PAGES   = pfaf_pkg::DISPLAY_PAGES_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	output logic            busy,
	input  wire logic [1:0] req_type,
	input  wire logic [7:0] start_x,
	input  wire logic [7:0] start_y,
	input  wire logic [7:0] area_width,
	input  wire logic [7:0] area_height,
	input  wire logic [1:0] draw_op,
	input  wire logic [2:0] read_page,
	input  wire logic [6:0] read_column,
	output logic            done,
	output logic [7:0]      read_data,
	output logic [7:0]      dirty_pages,
	output logic            start_error
);

`include "page_framebuffer_area_fill_macros.svh"

	localparam int ROWS  = DISPLAY_PAGES * pfaf_pkg::PAGE_ROWS;
	localparam int CW    = $clog2(DISPLAY_COLUMNS);
	localparam int PW    = (DISPLAY_PAGES > 1) ? $clog2(DISPLAY_PAGES) : 1;
	localparam int RW    = $clog2(ROWS + 1);
	localparam int AW    = PW + CW;
	localparam int DEPTH = 1 << AW;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FILL,
		ST_FLUSH,
		ST_READ,
		ST_CLR
	} state_t;

	state_t state_q;

	// sequencer registers
	logic [PW-1:0] page_q, last_page_q;
	logic [CW-1:0] col_q, first_col_q, last_col_q;
	logic [RW-1:0] sy_q, row_end_q;
	pfaf_pkg::op_t op_q;
	logic [AW-1:0] clr_q;
	logic          clr_report_q;
	logic          rd_ok_q;
	logic [7:0]    dirty_q;

	// write stage
	logic          wr_valid_s1;
	logic [AW-1:0] wr_addr_s1;
	logic [7:0]    mask_s1;
	pfaf_pkg::op_t op_s1;

	// registered result
	logic       done_q;
	logic [7:0] read_data_q, dirty_pages_q;
	logic       start_error_q;

	// RAM ports
	logic          ram_we;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [7:0]    ram_wdata, ram_rdata;

	// fill setup from the request fields
	logic [8:0]    col_sum, col_end, row_sum, row_end, last_row;
	logic [PW-1:0] first_page, last_page;
	logic          fill_err, fill_empty, rd_ok;
	logic [7:0]    dirty_range;

	always_comb begin
		col_sum  = 9'(start_x) + 9'(area_width);
		col_end  = (col_sum > 9'(DISPLAY_COLUMNS)) ? 9'(DISPLAY_COLUMNS) : col_sum;
		row_sum  = 9'(start_y) + 9'(area_height);
		row_end  = (row_sum > 9'(ROWS)) ? 9'(ROWS) : row_sum;
		last_row = (row_end > 9'(start_y)) ? row_end - 9'd1 : 9'(start_y);
		first_page = PW'(start_y >> 3);
		last_page  = PW'(last_row >> 3);
		fill_err   = (9'(start_x) >= 9'(DISPLAY_COLUMNS)) || (9'(start_y) >= 9'(ROWS));
		fill_empty = (col_end == 9'(start_x));
		for (int i = 0; i < 8; i++) begin
			dirty_range[i] = (4'(i) >= 4'(first_page)) && (4'(i) <= 4'(last_page));
		end
		rd_ok = (4'(read_page) < 4'(DISPLAY_PAGES)) && (9'(read_column) < 9'(DISPLAY_COLUMNS));
	end

	// vertical row mask of the current page
	logic [7:0] row_mask;
	always_comb begin
		for (int i = 0; i < 8; i++) begin
			row_mask[i] = (9'({page_q, 3'(i)}) >= 9'(sy_q))
				&& (9'({page_q, 3'(i)}) < 9'(row_end_q));
		end
	end

	// RAM port steering
	always_comb begin
		ram_raddr = (state_q == ST_FILL) ? {page_q, col_q}
			: {PW'(read_page), CW'(read_column)};
		if (state_q == ST_CLR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_q;
			ram_wdata = '0;
		end else begin
			ram_we    = wr_valid_s1;
			ram_waddr = wr_addr_s1;
			ram_wdata = pfaf_pkg::apply_op(ram_rdata, mask_s1, op_s1);
		end
	end

	pfaf_ram #(
		.WIDTH(8),
		.DEPTH(DEPTH)
	) u_frame_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// sequencer, write stage and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_CLR;
			page_q        <= '0;
			last_page_q   <= '0;
			col_q         <= '0;
			first_col_q   <= '0;
			last_col_q    <= '0;
			sy_q          <= '0;
			row_end_q     <= '0;
			op_q          <= pfaf_pkg::OP_OR;
			clr_q         <= '0;
			clr_report_q  <= 1'b0;
			rd_ok_q       <= 1'b0;
			dirty_q       <= pfaf_pkg::MASK_ALL;
			wr_valid_s1   <= 1'b0;
			wr_addr_s1    <= '0;
			mask_s1       <= '0;
			op_s1         <= pfaf_pkg::OP_OR;
			done_q        <= 1'b0;
			read_data_q   <= '0;
			dirty_pages_q <= '0;
			start_error_q <= 1'b0;
		end else begin
			done_q      <= 1'b0;
			wr_valid_s1 <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						read_data_q   <= '0;
						dirty_pages_q <= dirty_q;
						start_error_q <= 1'b0;
						unique case (pfaf_pkg::req_t'(req_type))
							pfaf_pkg::REQ_FILL: begin
								if (fill_err) begin
									start_error_q <= 1'b1;
									done_q        <= 1'b1;
								end else begin
									dirty_q <= dirty_q | dirty_range;
									if (fill_empty) begin
										done_q <= 1'b1;
									end else begin
										page_q      <= first_page;
										last_page_q <= last_page;
										col_q       <= CW'(start_x);
										first_col_q <= CW'(start_x);
										last_col_q  <= CW'(col_end - 9'd1);
										sy_q        <= RW'(start_y);
										row_end_q   <= RW'(row_end);
										op_q        <= pfaf_pkg::op_t'(draw_op);
										state_q     <= ST_FILL;
									end
								end
							end
							pfaf_pkg::REQ_READ: begin
								rd_ok_q <= rd_ok;
								state_q <= ST_READ;
							end
							pfaf_pkg::REQ_TAKE_DIRTY: begin
								dirty_q <= '0;
								done_q  <= 1'b1;
							end
							pfaf_pkg::REQ_CLEAR: begin
								clr_q        <= '0;
								clr_report_q <= 1'b1;
								state_q      <= ST_CLR;
							end
							default: begin
								done_q <= 1'b1;
							end
						endcase
					end
				end
				ST_FILL: begin
					// read issued this cycle; modify and write next cycle
					wr_valid_s1 <= 1'b1;
					wr_addr_s1  <= {page_q, col_q};
					mask_s1     <= row_mask;
					op_s1       <= op_q;
					if (col_q == last_col_q) begin
						col_q <= first_col_q;
						if (page_q == last_page_q) begin
							state_q <= ST_FLUSH;
						end else begin
							page_q <= page_q + PW'(1);
						end
					end else begin
						col_q <= col_q + CW'(1);
					end
				end
				ST_FLUSH: begin
					// last write lands this cycle
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				ST_READ: begin
					read_data_q <= rd_ok_q ? ram_rdata : 8'h00;
					done_q      <= 1'b1;
					state_q     <= ST_IDLE;
				end
				ST_CLR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(DEPTH - 1)) begin
						dirty_q      <= pfaf_pkg::MASK_ALL;
						done_q       <= clr_report_q;
						clr_report_q <= 1'b0;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy        = (state_q != ST_IDLE);
	assign done        = done_q;
	assign read_data   = read_data_q;
	assign dirty_pages = dirty_pages_q;
	assign start_error = start_error_q;

	// no write may still be pending once the block takes requests
	`PFAF_ASSERT_IMPLIES(a_idle_no_write, clk, arst_n, !busy, !wr_valid_s1)
	// a rejected fill never returns data
	`PFAF_ASSERT_IMPLIES(a_err_no_data, clk, arst_n, done && start_error, read_data == 8'h00)
	// the last fill write finishes before the result is shown
	`PFAF_ASSERT_NEXT(a_flush_done, clk, arst_n, state_q == ST_FLUSH, done && !wr_valid_s1)
	// a take of the dirty mask leaves it empty
	`PFAF_ASSERT_NEXT(a_take_clears, clk, arst_n,
		start && !busy && (req_type == pfaf_pkg::REQ_TAKE_DIRTY), dirty_q == 8'h00)

endmodule
`default_nettype wire

>>> rtl/core/pfaf_ram.sv
`default_nettype none
// Simple dual-port RAM: one write port, one read port with registered data.
module pfaf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire
